// ----- sv/calendar_date_counter_unit_defines.svh -----
// Assertion macros shared by the calendar date counter checker.
`ifndef CALENDAR_DATE_COUNTER_UNIT_DEFINES_SVH
`define CALENDAR_DATE_COUNTER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CAL_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("calendar date counter check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CAL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("calendar date counter check failed");

`endif

// ----- sv/cal_pkg.sv -----
// Types, codes and calendar helper functions for the calendar date counter.
package cal_pkg;

    localparam int COUNT_BITS = 16;
    typedef logic [COUNT_BITS-1:0] count_t;

    localparam logic [1:0] KIND_SET     = 2'd0;
    localparam logic [1:0] KIND_ADVANCE = 2'd1;
    localparam logic [1:0] KIND_ADD     = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_MONTH = 3'd1;
    localparam logic [2:0] ST_BAD_YEAR  = 3'd2;
    localparam logic [2:0] ST_BAD_DAY   = 3'd3;
    localparam logic [2:0] ST_OVERFLOW  = 3'd4;

    localparam logic [11:0] YEAR_RESET   = 12'd1900;
    localparam logic [11:0] YEAR_SET_MIN = 12'd1900;
    localparam logic [11:0] YEAR_SET_MAX = 12'd2100;
    localparam logic [11:0] YEAR_MAX     = 12'd4095;
    localparam logic [3:0]  MONTH_LAST   = 4'd12;
    localparam logic [3:0]  MONTH_FEB    = 4'd2;
    localparam logic [4:0]  FEB_LEAP_LEN = 5'd29;
    localparam logic [4:0]  DEC_LEN      = 5'd31;

    // Century years that fit in 12 bits: 0, 100, ... 4000.
    localparam int CENTURIES = 41;

    localparam logic [4:0] MONTH_LEN [0:12] = '{
        5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef enum logic [1:0] {
        SRC_SET,
        SRC_STEP,
        SRC_ADD,
        SRC_NONE
    } push_src_t;

    typedef struct packed {
        logic      set;
        logic      step;
        logic      cnt_load;
        logic      cnt_dec;
        logic      push;
        push_src_t src;
    } cmd_t;

    typedef struct packed {
        logic cnt_zero;
        logic at_max;
    } stat_t;

    // 400/100/4 rule; the century test compares against constant multiples of 100.
    function automatic logic is_leap(input logic [11:0] y);
        logic cent;
        logic cent_leap;
        cent      = 1'b0;
        cent_leap = 1'b0;
        for (int k = 0; k < CENTURIES; k++) begin
            if (y == 12'(k * 100)) begin
                cent      = 1'b1;
                cent_leap = ((k & 3) == 0);
            end
        end
        return (y[1:0] == 2'b00) && (!cent || cent_leap);
    endfunction

    // Months outside 1..12 count as 31 days.
    function automatic logic [4:0] last_day(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        len = DEC_LEN;
        if (m inside {[1:12]}) begin
            len = MONTH_LEN[m];
        end
        if (m == MONTH_FEB && leap) begin
            len = FEB_LEAP_LEN;
        end
        return len;
    endfunction

endpackage

// ----- sv/cal_datapath.sv -----
// Date registers, day stepper, set checker, add counter and result register.
module cal_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  cal_pkg::cmd_t     cmd,
    input  logic [3:0]        new_month,
    input  logic [4:0]        new_day,
    input  logic [11:0]       new_year,
    input  logic [15:0]       day_count,
    output cal_pkg::stat_t    stat,
    output logic [3:0]        cur_month,
    output logic [4:0]        cur_day,
    output logic [11:0]       cur_year,
    output logic [2:0]        status
);

    logic [4:0]      day_reg, day_next;
    logic [3:0]      month_reg, month_next;
    logic [11:0]     year_reg, year_next;
    cal_pkg::count_t cnt_reg, cnt_next;
    logic [3:0]      out_month_reg;
    logic [4:0]      out_day_reg;
    logic [11:0]     out_year_reg;
    logic [2:0]      out_status_reg, out_status_next;
    logic [4:0]      cur_last;
    logic [4:0]      set_last;
    logic [2:0]      set_status;
    logic            at_max;

    assign cur_last = cal_pkg::last_day(month_reg, cal_pkg::is_leap(year_reg));
    assign set_last = cal_pkg::last_day(new_month, cal_pkg::is_leap(new_year));

    // Last day of the last representable year: a step would need year 4096.
    assign at_max = (day_reg >= cur_last) && (month_reg >= cal_pkg::MONTH_LAST)
                    && (year_reg >= cal_pkg::YEAR_MAX);

    always_comb
    begin
        if (!(new_month inside {[1:12]})) begin
            set_status = cal_pkg::ST_BAD_MONTH;
        end else if (!(new_year inside {[cal_pkg::YEAR_SET_MIN:cal_pkg::YEAR_SET_MAX]})) begin
            set_status = cal_pkg::ST_BAD_YEAR;
        end else if (new_day == 5'd0 || new_day > set_last) begin
            set_status = cal_pkg::ST_BAD_DAY;
        end else begin
            set_status = cal_pkg::ST_OK;
        end
    end

    always_comb
    begin
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;
        if (cmd.set && set_status == cal_pkg::ST_OK) begin
            day_next   = new_day;
            month_next = new_month;
            year_next  = new_year;
        end else if (cmd.step && !at_max) begin
            if (day_reg < cur_last) begin
                day_next = day_reg + 5'd1;
            end else if (month_reg < cal_pkg::MONTH_LAST) begin
                month_next = month_reg + 4'd1;
                day_next   = 5'd1;
            end else begin
                year_next  = year_reg + 12'd1;
                month_next = 4'd1;
                day_next   = 5'd1;
            end
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.cnt_load) begin
            cnt_next = cal_pkg::count_t'(day_count);
        end else if (cmd.cnt_dec) begin
            cnt_next = cnt_reg - cal_pkg::count_t'(1);
        end
    end

    always_comb
    begin
        case (cmd.src)
            cal_pkg::SRC_SET:  out_status_next = set_status;
            cal_pkg::SRC_STEP: out_status_next = at_max ? cal_pkg::ST_OVERFLOW : cal_pkg::ST_OK;
            cal_pkg::SRC_ADD:  out_status_next = (cnt_reg == '0) ? cal_pkg::ST_OK
                                                                 : cal_pkg::ST_OVERFLOW;
            default:           out_status_next = cal_pkg::ST_OK;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            day_reg   <= 5'd1;
            month_reg <= 4'd1;
            year_reg  <= cal_pkg::YEAR_RESET;
        end else begin
            day_reg   <= day_next;
            month_reg <= month_next;
            year_reg  <= year_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        if (cmd.push) begin
            out_month_reg  <= month_next;
            out_day_reg    <= day_next;
            out_year_reg   <= year_next;
            out_status_reg <= out_status_next;
        end
    end

    assign stat.cnt_zero = (cnt_reg == '0);
    assign stat.at_max   = at_max;

    assign cur_month = out_month_reg;
    assign cur_day   = out_day_reg;
    assign cur_year  = out_year_reg;
    assign status    = out_status_reg;

endmodule

// ----- sv/cal_ctrl.sv -----
// Request sequencer: decodes the item kind, runs add requests and owns the result valid.
module cal_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [1:0]     kind,
    output logic           out_valid,
    input  logic           out_ready,
    input  cal_pkg::stat_t stat,
    output cal_pkg::cmd_t  cmd
);

    typedef enum logic {
        S_IDLE,
        S_ADD
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && slot_free;

    always_comb
    begin
        cmd        = '0;
        cmd.src    = cal_pkg::SRC_NONE;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready) begin
                    case (kind)
                        cal_pkg::KIND_SET:
                        begin
                            cmd.set  = 1'b1;
                            cmd.push = 1'b1;
                            cmd.src  = cal_pkg::SRC_SET;
                        end
                        cal_pkg::KIND_ADVANCE:
                        begin
                            cmd.step = 1'b1;
                            cmd.push = 1'b1;
                            cmd.src  = cal_pkg::SRC_STEP;
                        end
                        cal_pkg::KIND_ADD:
                        begin
                            cmd.cnt_load = 1'b1;
                            state_next   = S_ADD;
                        end
                        default:
                        begin
                            cmd.push = 1'b1;
                        end
                    endcase
                end
            end
            S_ADD:
            begin
                // one day per cycle until the count runs out or the year tops out
                if (!stat.cnt_zero && !stat.at_max) begin
                    cmd.step    = 1'b1;
                    cmd.cnt_dec = 1'b1;
                end else if (slot_free) begin
                    cmd.push   = 1'b1;
                    cmd.src    = cal_pkg::SRC_ADD;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.push) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- sv/calendar_date_counter_unit.sv -----
// Top level of the calendar date counter: stream ports, sequencer and datapath.
//
//  channel | direction | fields
//  --------+-----------+---------------------------------------------------
//  s_*     | in        | tuser: kind; tdata: new_month, new_day, new_year, day_count
//  m_*     | out       | tdata: cur_month, cur_day, cur_year, status
//
// Set, advance and unused kinds push their result on accept; it is registered and shown in the next cycle.
// An add of N days runs in order: count load, one day per cycle, result write;
// fewer days if the year tops out at 4095. Input is held off while an add runs.
// A waiting result holds input off unless m_tready takes it in the same cycle,
// and a finished add waits for the result slot to free up.
// Reset (rst_n low, asynchronous) sets the date to January 1, 1900 and drops m_tvalid.
module calendar_date_counter_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // new_month[3:0], new_day[8:4], new_year[20:9],
                                   // day_count[36:21], zero[39:37]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // cur_month[3:0], cur_day[8:4], cur_year[20:9],
                                   // status[23:21]
);

    cal_pkg::cmd_t  cmd;
    cal_pkg::stat_t stat;
    logic [3:0]     cur_month;
    logic [4:0]     cur_day;
    logic [11:0]    cur_year;
    logic [2:0]     status;

    cal_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .kind      (s_tuser),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    cal_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .new_month (s_tdata[3:0]),
        .new_day   (s_tdata[8:4]),
        .new_year  (s_tdata[20:9]),
        .day_count (s_tdata[36:21]),
        .stat      (stat),
        .cur_month (cur_month),
        .cur_day   (cur_day),
        .cur_year  (cur_year),
        .status    (status)
    );

    assign m_tdata = {status, cur_year, cur_day, cur_month};

endmodule

// ----- sv/cal_checker.sv -----
// Port-level checks for the calendar date counter, bound to the top level.
`include "calendar_date_counter_unit_defines.svh"

module cal_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [39:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // a stalled result must hold
    `CAL_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // the shown date has a month in 1..12, a nonzero day and a year of at least 1900
    `CAL_ASSERT_NOW(a_date_sane, m_tvalid,
        m_tdata[3:0] >= 4'd1 && m_tdata[3:0] <= 4'd12 && m_tdata[8:4] >= 5'd1
        && m_tdata[20:9] >= cal_pkg::YEAR_RESET)

    // overflow only ever reports the last day of the last year
    `CAL_ASSERT_NOW(a_ovf_date, m_tvalid && m_tdata[23:21] == cal_pkg::ST_OVERFLOW,
        m_tdata[3:0] == cal_pkg::MONTH_LAST && m_tdata[8:4] == cal_pkg::DEC_LEN
        && m_tdata[20:9] == cal_pkg::YEAR_MAX)

    // a set or advance item produces its result on the next cycle
    `CAL_ASSERT_NEXT(a_short_latency,
        s_tvalid && s_tready && (s_tuser == cal_pkg::KIND_SET
        || s_tuser == cal_pkg::KIND_ADVANCE), m_tvalid)

endmodule

bind calendar_date_counter_unit cal_checker u_cal_checker (.*);
